FILE: rtl/hse_pkg.sv
// Shared definitions for the Hermite segment evaluator: field widths, fixed-point
// formats, register indexes, result record and the output saturation helper.
// No dependencies.
package hse_pkg;

	// Field formats
	localparam int FIELD_W           = 24;
	localparam int TOL_W             = 16;
	localparam int COORD_FRAC_BITS   = 8;
	localparam int TANGENT_FRAC_BITS = 16;

	// Hit tolerance after reset: seven pixels
	localparam int TOL_RESET_PIXELS  = 7;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(TOL_RESET_PIXELS << COORD_FRAC_BITS);

	// Chunk width of the split multipliers
	localparam int MUL_CHUNK_W = 24;

	// Quotient bits resolved by the dividers; larger magnitudes saturate anyway
	localparam int DIV_QUO_BITS = 25;

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_X,
		REG_START_Y,
		REG_FINISH_X,
		REG_FINISH_Y,
		REG_START_TANGENT,
		REG_FINISH_TANGENT,
		REG_HIT_TOLERANCE
	} reg_idx_t;

	// One result record
	typedef struct packed {
		logic signed [FIELD_W-1:0] curve_y;
		logic signed [FIELD_W-1:0] curve_tangent;
		logic                      hit;
		logic                      degenerate;
	} result_t;

	localparam logic signed [31:0] SAT_HI = 32'sd8388607;
	localparam logic signed [31:0] SAT_LO = -32'sd8388608;

	// Clamp to the signed field range
	function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [31:0] v);
		if (v > SAT_HI) begin
			sat_field = FIELD_W'(SAT_HI);
		end else if (v < SAT_LO) begin
			sat_field = FIELD_W'(SAT_LO);
		end else begin
			sat_field = FIELD_W'(v);
		end
	endfunction

endpackage

FILE: rtl/hse_mul.sv
// Two-stage signed multiplier for a wide operand times a narrow one.
// Stage one forms chunk partial products, stage two sums them. Uses hse_pkg.
module hse_mul #(
	parameter int WA = 49,
	parameter int WB = 25
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] prod
);
	import hse_pkg::*;

	localparam int CW     = MUL_CHUNK_W;
	localparam int NC     = (WA + CW - 1) / CW;
	localparam int AX     = NC * CW;
	localparam int PW     = CW + 1 + WB;
	localparam int PROD_W = WA + WB;

	logic signed [AX-1:0] a_ext;
	logic signed [CW:0]   op [NC];
	logic signed [PW-1:0] pp_s1 [NC];
	logic signed [PROD_W-1:0] acc;

	assign a_ext = AX'(a);

	// Low chunks unsigned, top chunk carries the sign
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			op[i] = {(i == NC - 1) ? a_ext[i*CW+CW-1] : 1'b0, a_ext[i*CW +: CW]};
		end
	end

	// Partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				pp_s1[i] <= op[i] * b;
			end
		end
	end

	// Shifted sum of partials
	always_comb begin
		acc = '0;
		for (int i = 0; i < NC; i++) begin
			acc = acc + (PROD_W'(pp_s1[i]) <<< (i * CW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= acc;
		end
	end

endmodule

FILE: rtl/hse_rdiv.sv
// Pipelined rounding divider: round(num / den), ties toward plus infinity,
// magnitude clamped to 2^QB. One quotient bit per restoring stage. No package use.
module hse_rdiv #(
	parameter int WN = 130,
	parameter int WD = 88,
	parameter int QB = 25
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [WN-1:0]   num,
	input  logic        [WD-1:0]   den,
	output logic signed [QB+1:0]   quo
);

	localparam int MW = ((WN > WD + 1) ? WN : WD + 1) + 2;
	localparam int RW = ((MW + 1) > (WD + 2 + QB)) ? MW + 1 : WD + 2 + QB;

	logic signed [MW-1:0] m;
	logic        [MW-1:0] m_mag;
	logic                 m_neg;
	logic        [RW-1:0] p_in;
	logic        [RW-1:0] r_in;

	logic [RW-1:0] r_s1;
	logic [RW-1:0] p_s1;
	logic          neg_s1;

	logic [RW-1:0] rem_s   [2:QB+1];
	logic [RW-1:0] p_s     [2:QB+1];
	logic [QB-1:0] q_s     [2:QB+2];
	logic          neg_s   [2:QB+2];
	logic          clamp_s [2:QB+2];

	logic [QB:0]   mag;

	// Fold the rounding into an exact floor: m = 2*num + den over p = 2*den
	always_comb begin
		m     = (MW'(num) <<< 1) + MW'({1'b0, den});
		m_neg = m[MW-1];
		m_mag = m_neg ? (~m + MW'(1)) : m;
		p_in  = RW'({den, 1'b0});
		r_in  = RW'(m_mag) + (m_neg ? (p_in - RW'(1)) : '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r_in;
			p_s1   <= p_in;
			neg_s1 <= m_neg;
		end
	end

	// Clamp check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[2]   <= r_s1;
			p_s[2]     <= p_s1;
			q_s[2]     <= '0;
			neg_s[2]   <= neg_s1;
			clamp_s[2] <= (r_s1 >= (p_s1 << QB));
		end
	end

	// Restoring steps, most significant quotient bit first
	for (genvar k = 2; k <= QB + 1; k++) begin : g_step
		localparam int B = QB + 1 - k;
		logic ge;
		assign ge = (rem_s[k] >= (p_s[k] << B));

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]     <= q_s[k] | (QB'(ge) << B);
				neg_s[k+1]   <= neg_s[k];
				clamp_s[k+1] <= clamp_s[k];
			end
		end

		if (k < QB + 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? (rem_s[k] - (p_s[k] << B)) : rem_s[k];
					p_s[k+1]   <= p_s[k];
				end
			end
		end
	end

	// Apply clamp and sign
	assign mag = clamp_s[QB+2] ? ((QB+1)'(1) << QB) : {1'b0, q_s[QB+2]};

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QB+2] ? -$signed((QB+2)'(mag)) : $signed((QB+2)'(mag));
		end
	end

endmodule

FILE: rtl/hermite_segment_evaluator.sv
// Cubic Hermite segment evaluator top level: configuration registers, coefficient
// and Horner pipeline, hit test, output queue. Uses hse_pkg, hse_mul, hse_rdiv.
//
// Usage:
//   Write the segment (endpoints, end tangents, hit tolerance) on the cfg channel
//   while no query is in flight; cfg_ready is always high.
//   Queries enter on query_valid/query_stall, results leave on
//   result_valid/result_stall, one result per query, in order.
//   Throughput: one query per cycle while query_stall is low. Each result passes
//   through the 12 multiply/add stages ahead of the two dividers, their 28
//   stages (one quotient bit per restoring stage) and then the output queue.
//   A two-entry queue sits behind the pipeline. The pipeline freezes only when
//   the queue is full, its head is not taken and the last stage holds a result;
//   query_stall is high exactly then. Nothing is lost or repeated on a stall.
//   Reset clears all valid bits and the queue and loads the register defaults
//   (all zero, tolerance seven pixels).
//   A segment with zero x extent gives degenerate=1 and all other fields 0.
module hermite_segment_evaluator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hse_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [hse_pkg::FIELD_W-1:0]         cfg_data,
	input  logic                                query_valid,
	output logic                                query_stall,
	input  logic signed [hse_pkg::FIELD_W-1:0]  query_x,
	input  logic signed [hse_pkg::FIELD_W-1:0]  query_y,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [hse_pkg::FIELD_W-1:0]  curve_y,
	output logic signed [hse_pkg::FIELD_W-1:0]  curve_tangent,
	output logic                                hit,
	output logic                                degenerate
);
	import hse_pkg::*;

	localparam int TF      = TANGENT_FRAC_BITS;
	localparam int DX_W    = FIELD_W + 1;
	localparam int T_W     = FIELD_W + 1;
	localparam int DX2_W   = DX_W + 1;
	localparam int T3_W    = T_W + 2;
	localparam int AD_W    = FIELD_W;
	localparam int SS_W    = FIELD_W + 2;
	localparam int E1_W    = DX_W + FIELD_W;
	localparam int M1_W    = DX_W + SS_W;
	localparam int M2_W    = DX_W + DX_W;
	localparam int ADX2_W  = 2 * AD_W;
	localparam int AP_W    = ((DX_W + 3 + TF) > (M1_W + 1)) ? DX_W + 3 + TF : M1_W + 1;
	localparam int ED_W    = E1_W + DX_W;
	localparam int LEAD_W  = ED_W + DX2_W;
	localparam int CUBE_W  = 3 * AD_W;
	localparam int CUBEM_W = ADX2_W + 1 + AD_W + 1;
	localparam int N1A_W   = AP_W + T_W;
	localparam int N1_W    = N1A_W + 1;
	localparam int GA_W    = AP_W + DX2_W;
	localparam int GB_W    = AP_W + T3_W;
	localparam int G1_W    = GB_W + 1;
	localparam int N2M_W   = N1_W + T_W;
	localparam int N2_W    = ((N2M_W > LEAD_W) ? N2M_W : LEAD_W) + 1;
	localparam int G2M_W   = G1_W + T_W;
	localparam int G2_W    = ((G2M_W > LEAD_W) ? G2M_W : LEAD_W) + 1;
	localparam int N3_W    = N2_W + T_W;
	localparam int NQ_W    = N3_W + 1;
	localparam int TN_W    = G2_W + 1;
	localparam int CDQ_W   = CUBE_W + 1 + DX_W;
	localparam int THR_W   = CUBE_W + 1 + TOL_W + 1;
	localparam int D_W     = CUBE_W + TF;
	localparam int S_W     = NQ_W + 1;
	localparam int QW      = DIV_QUO_BITS + 2;
	localparam int LAT     = DIV_QUO_BITS + 3;
	localparam int SD      = 12 + LAT;

	// Configuration registers
	logic signed [FIELD_W-1:0] start_x_q, start_y_q, finish_x_q, finish_y_q;
	logic signed [FIELD_W-1:0] start_tangent_q, finish_tangent_q;
	logic        [TOL_W-1:0]   hit_tolerance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q        <= '0;
			start_y_q        <= '0;
			finish_x_q       <= '0;
			finish_y_q       <= '0;
			start_tangent_q  <= '0;
			finish_tangent_q <= '0;
			hit_tolerance_q  <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_X:        start_x_q        <= cfg_data;
				REG_START_Y:        start_y_q        <= cfg_data;
				REG_FINISH_X:       finish_x_q       <= cfg_data;
				REG_FINISH_Y:       finish_y_q       <= cfg_data;
				REG_START_TANGENT:  start_tangent_q  <= cfg_data;
				REG_FINISH_TANGENT: finish_tangent_q <= cfg_data;
				REG_HIT_TOLERANCE:  hit_tolerance_q  <= cfg_data[TOL_W-1:0];
				default:            ;
			endcase
		end
	end

	// Pipeline control
	logic en;
	logic pop;
	logic full;
	logic v_s [1:SD];

	assign query_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SD; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= query_valid;
			for (int k = 2; k <= SD; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// Stage 1: differences and sums, plus the dx/t/dyq delay lines
	logic signed [DX_W-1:0]    dx_in;
	logic        [AD_W-1:0]    adx_in;
	logic signed [DX_W-1:0]    dx_s   [1:11];
	logic signed [T_W-1:0]     t_s    [1:9];
	logic signed [DX2_W-1:0]   ndx_s  [1:4];
	logic signed [DX_W-1:0]    dyq_s  [1:4];
	logic signed [DX_W-1:0]    dy_s1, dy_s2;
	logic signed [SS_W-1:0]    st2ft_s1;
	logic signed [DX_W-1:0]    sumt_s1;
	logic        [AD_W-1:0]    adx_s1, adx_s2;

	assign dx_in  = DX_W'(finish_x_q) - DX_W'(start_x_q);
	assign adx_in = dx_in[DX_W-1] ? AD_W'(-dx_in) : AD_W'(dx_in);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s[1]  <= dx_in;
			t_s[1]   <= T_W'(query_x) - T_W'(start_x_q);
			ndx_s[1] <= -DX2_W'(dx_in);
			dyq_s[1] <= DX_W'(start_y_q) - DX_W'(query_y);
			dy_s1    <= DX_W'(finish_y_q) - DX_W'(start_y_q);
			st2ft_s1 <= (SS_W'(start_tangent_q) <<< 1) + SS_W'(finish_tangent_q);
			sumt_s1  <= DX_W'(start_tangent_q) + DX_W'(finish_tangent_q);
			adx_s1   <= adx_in;
			for (int k = 2; k <= 11; k++) dx_s[k]  <= dx_s[k-1];
			for (int k = 2; k <= 9; k++)  t_s[k]   <= t_s[k-1];
			for (int k = 2; k <= 4; k++)  ndx_s[k] <= ndx_s[k-1];
			for (int k = 2; k <= 4; k++)  dyq_s[k] <= dyq_s[k-1];
		end
	end

	// Stage 2: narrow products, degenerate flag delay line
	logic signed [E1_W-1:0]   e1_s2;
	logic signed [M1_W-1:0]   m1_s2;
	logic signed [M2_W-1:0]   m2_s2;
	logic        [ADX2_W-1:0] adx2_s2;
	logic                     deg_s [2:SD];

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s2   <= E1_W'(dx_s[1]) * E1_W'(start_tangent_q);
			m1_s2   <= M1_W'(dx_s[1]) * M1_W'(st2ft_s1);
			m2_s2   <= M2_W'(dx_s[1]) * M2_W'(sumt_s1);
			adx2_s2 <= ADX2_W'(adx_s1) * ADX2_W'(adx_s1);
			dy_s2   <= dy_s1;
			adx_s2  <= adx_s1;
			deg_s[2] <= (dx_s[1] == '0);
			for (int k = 3; k <= SD; k++) deg_s[k] <= deg_s[k-1];
		end
	end

	// Stage 3: Hermite coefficients ap, bp
	logic signed [AP_W-1:0] ap_s3, bp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s3 <= (((AP_W'(dy_s2) <<< 1) + AP_W'(dy_s2)) <<< TF) + AP_W'(m1_s2);
			bp_s3 <= -(AP_W'(dy_s2) <<< (TF + 1)) - AP_W'(m2_s2);
		end
	end

	// e1*dx and |dx|^3, ready at stage 4
	logic signed [ED_W-1:0]    ed_w;
	logic signed [CUBEM_W-1:0] cubem_w;
	logic        [CUBE_W-1:0]  cube_s [5:12];

	hse_mul #(.WA(E1_W), .WB(DX_W)) u_mul_ed (
		.clk(clk), .en(en), .a(e1_s2), .b(dx_s[2]), .prod(ed_w)
	);

	hse_mul #(.WA(ADX2_W + 1), .WB(AD_W + 1)) u_mul_cube (
		.clk(clk), .en(en),
		.a($signed({1'b0, adx2_s2})), .b($signed({1'b0, adx_s2})), .prod(cubem_w)
	);

	// Inner Horner terms, ready at stage 5
	logic signed [DX2_W-1:0] dx2_w;
	logic signed [T3_W-1:0]  t3_w;
	logic signed [N1A_W-1:0] n1a_w, n1b_w;
	logic signed [GA_W-1:0]  ga_w;
	logic signed [GB_W-1:0]  gb_w;

	assign dx2_w = DX2_W'(dx_s[3]) <<< 1;
	assign t3_w  = (T3_W'(t_s[3]) <<< 1) + T3_W'(t_s[3]);

	hse_mul #(.WA(AP_W), .WB(T_W)) u_mul_n1a (
		.clk(clk), .en(en), .a(bp_s3), .b(t_s[3]), .prod(n1a_w)
	);
	hse_mul #(.WA(AP_W), .WB(DX_W)) u_mul_n1b (
		.clk(clk), .en(en), .a(ap_s3), .b(dx_s[3]), .prod(n1b_w)
	);
	hse_mul #(.WA(AP_W), .WB(DX2_W)) u_mul_ga (
		.clk(clk), .en(en), .a(ap_s3), .b(dx2_w), .prod(ga_w)
	);
	hse_mul #(.WA(AP_W), .WB(T3_W)) u_mul_gb (
		.clk(clk), .en(en), .a(bp_s3), .b(t3_w), .prod(gb_w)
	);

	// Leading term and hit-test products, ready at stage 6
	logic signed [LEAD_W-1:0] lead_w, lead_s7, lead_s8;
	logic signed [CDQ_W-1:0]  cdq_w;
	logic signed [CDQ_W-1:0]  cdq_s [7:12];
	logic signed [THR_W-1:0]  thr_w;
	logic signed [THR_W-1:0]  thr_s [7:13];

	hse_mul #(.WA(ED_W), .WB(DX2_W)) u_mul_lead (
		.clk(clk), .en(en), .a(ed_w), .b(ndx_s[4]), .prod(lead_w)
	);
	hse_mul #(.WA(CUBE_W + 1), .WB(DX_W)) u_mul_cdq (
		.clk(clk), .en(en),
		.a($signed({1'b0, cubem_w[CUBE_W-1:0]})), .b(dyq_s[4]), .prod(cdq_w)
	);
	hse_mul #(.WA(CUBE_W + 1), .WB(TOL_W + 1)) u_mul_thr (
		.clk(clk), .en(en),
		.a($signed({1'b0, cubem_w[CUBE_W-1:0]})), .b($signed({1'b0, hit_tolerance_q})),
		.prod(thr_w)
	);

	// Stage 6: first Horner sums
	logic signed [N1_W-1:0] n1_s6;
	logic signed [G1_W-1:0] g1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s6 <= N1_W'(n1a_w) + N1_W'(n1b_w);
			g1_s6 <= G1_W'(ga_w) + G1_W'(gb_w);
		end
	end

	// Times t, ready at stage 8
	logic signed [N2M_W-1:0] n2m_w;
	logic signed [G2M_W-1:0] g2m_w;

	hse_mul #(.WA(N1_W), .WB(T_W)) u_mul_n2 (
		.clk(clk), .en(en), .a(n1_s6), .b(t_s[6]), .prod(n2m_w)
	);
	hse_mul #(.WA(G1_W), .WB(T_W)) u_mul_g2 (
		.clk(clk), .en(en), .a(g1_s6), .b(t_s[6]), .prod(g2m_w)
	);

	// Stage 9: add leading term
	logic signed [N2_W-1:0] n2_s9;
	logic signed [G2_W-1:0] g2_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s9 <= N2_W'(n2m_w) + N2_W'(lead_s8);
			g2_s9 <= G2_W'(g2m_w) + G2_W'(lead_s8);
		end
	end

	// Tangent numerator with screen sign, stages 10 to 12
	logic signed [TN_W-1:0] tn_s10, tn_s11, tn_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			tn_s10 <= dx_s[9][DX_W-1] ? TN_W'(g2_s9) : -TN_W'(g2_s9);
			tn_s11 <= tn_s10;
			tn_s12 <= tn_s11;
		end
	end

	// Final times t, ready at stage 11; sign fold for negative dx
	logic signed [N3_W-1:0] n3_w;
	logic signed [NQ_W-1:0] nq_s12;

	hse_mul #(.WA(N2_W), .WB(T_W)) u_mul_n3 (
		.clk(clk), .en(en), .a(n2_s9), .b(t_s[9]), .prod(n3_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s12 <= dx_s[11][DX_W-1] ? -NQ_W'(n3_w) : NQ_W'(n3_w);
		end
	end

	// Hit test: |n + d*(sy - qy)| < d*tol, stages 13 and 14
	logic signed [S_W-1:0] s_s13;
	logic signed [S_W-1:0] s_abs;
	logic signed [S_W-1:0] thr_sh;
	logic                  hit_s [14:SD];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s13 <= S_W'(nq_s12) + (S_W'(cdq_s[12]) <<< TF);
		end
	end

	always_comb begin
		s_abs  = s_s13[S_W-1] ? -s_s13 : s_s13;
		thr_sh = S_W'(thr_s[13]) <<< TF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s[14] <= (s_abs < thr_sh);
			for (int k = 15; k <= SD; k++) hit_s[k] <= hit_s[k-1];
		end
	end

	// Dividers, both entered at stage 12
	logic        [D_W-1:0] d_w;
	logic signed [QW-1:0]  quo_y, quo_t;

	assign d_w = D_W'(cube_s[12]) << TF;

	hse_rdiv #(.WN(NQ_W), .WD(D_W), .QB(DIV_QUO_BITS)) u_div_y (
		.clk(clk), .en(en), .num(nq_s12), .den(d_w), .quo(quo_y)
	);
	hse_rdiv #(.WN(TN_W), .WD(CUBE_W), .QB(DIV_QUO_BITS)) u_div_t (
		.clk(clk), .en(en), .num(tn_s12), .den(cube_s[12]), .quo(quo_t)
	);

	// Side delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			cube_s[5] <= cubem_w[CUBE_W-1:0];
			for (int k = 6; k <= 12; k++) cube_s[k] <= cube_s[k-1];
			lead_s7 <= lead_w;
			lead_s8 <= lead_s7;
			cdq_s[7] <= cdq_w;
			for (int k = 8; k <= 12; k++) cdq_s[k] <= cdq_s[k-1];
			thr_s[7] <= thr_w;
			for (int k = 8; k <= 13; k++) thr_s[k] <= thr_s[k-1];
		end
	end

	// Final assembly with saturation
	logic signed [QW:0] y_sum;
	result_t            res;

	always_comb begin
		y_sum = (QW+1)'(start_y_q) + (QW+1)'(quo_y);
		if (deg_s[SD]) begin
			res.curve_y       = '0;
			res.curve_tangent = '0;
			res.hit           = 1'b0;
			res.degenerate    = 1'b1;
		end else begin
			res.curve_y       = sat_field(32'(y_sum));
			res.curve_tangent = sat_field(32'(quo_t));
			res.hit           = hit_s[SD];
			res.degenerate    = 1'b0;
		end
	end

	// Two-entry output queue
	result_t     fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign full         = (cnt_q == 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && !result_stall;
	assign en           = !v_s[SD] || !full || pop;
	assign push         = v_s[SD] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign curve_y       = fifo_q[rd_ptr_q].curve_y;
	assign curve_tangent = fifo_q[rd_ptr_q].curve_tangent;
	assign hit           = fifo_q[rd_ptr_q].hit;
	assign degenerate    = fifo_q[rd_ptr_q].degenerate;

endmodule
